@@ rtl/core/dop_pkg.sv @@
package dop_pkg;

  // one options-area byte with its end-of-area mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } dop_in_t;

  // parse summary given once per packet
  typedef struct packed {
    logic        status;
    logic [7:0]  message_type;
    logic [31:0] netmask;
    logic [31:0] router;
    logic [31:0] dns_primary;
    logic [31:0] dns_secondary;
    logic [31:0] broadcast_addr;
    logic [31:0] lease_seconds;
    logic [31:0] server_id;
    logic [31:0] renewal_seconds;
    logic [31:0] rebind_seconds;
  } dop_out_t;

endpackage

@@ rtl/core/dop_parse.sv @@
module dop_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  dop_pkg::dop_in_t  in_data_i,
  output logic              res_valid_o,
  output dop_pkg::dop_out_t res_data_o
);
  import dop_pkg::*;

  typedef enum logic [2:0] {
    PH_COOKIE = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_VALUE  = 3'd3,
    PH_STOP   = 3'd4,
    PH_BAD    = 3'd5
  } phase_e;

  localparam logic [7:0] COOKIE_BYTES [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_SUBNET    = 8'd1;
  localparam logic [7:0] OPT_ROUTER    = 8'd3;
  localparam logic [7:0] OPT_DNS       = 8'd6;
  localparam logic [7:0] OPT_BROADCAST = 8'd28;
  localparam logic [7:0] OPT_LEASE     = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
  localparam logic [7:0] OPT_SERVER    = 8'd54;
  localparam logic [7:0] OPT_RENEWAL   = 8'd58;
  localparam logic [7:0] OPT_REBIND    = 8'd59;
  localparam logic [7:0] OPT_END       = 8'd255;

  localparam int unsigned NumFields = 9;
  localparam logic [3:0] F_MASK   = 4'd0;
  localparam logic [3:0] F_ROUTER = 4'd1;
  localparam logic [3:0] F_DNS1   = 4'd2;
  localparam logic [3:0] F_DNS2   = 4'd3;
  localparam logic [3:0] F_BCAST  = 4'd4;
  localparam logic [3:0] F_LEASE  = 4'd5;
  localparam logic [3:0] F_SERVER = 4'd6;
  localparam logic [3:0] F_RENEW  = 4'd7;
  localparam logic [3:0] F_REBIND = 4'd8;

  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  off_q, off_d;
  logic [31:0] stage_q [2];
  logic [31:0] stage_d [2];
  logic [31:0] field_q [NumFields];
  logic [31:0] field_d [NumFields];
  logic [7:0]  type_q, type_d;
  logic        commit;
  logic [1:0]  lane;
  logic [7:0]  b;

  assign b    = in_data_i.data_byte;
  assign lane = 2'd3 - off_q[1:0];

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    code_d  = code_q;
    len_d   = len_q;
    off_d   = off_q;
    stage_d = stage_q;
    field_d = field_q;
    type_d  = type_q;
    commit  = 1'b0;

    unique case (phase_q)
      PH_COOKIE: begin
        if (b != COOKIE_BYTES[cnt_q]) begin
          phase_d = PH_BAD;
        end else begin
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            phase_d = PH_CODE;
          end
        end
      end
      PH_CODE: begin
        if (b == OPT_END) begin
          phase_d = PH_STOP;
        end else if (b != OPT_PAD) begin
          code_d  = b;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        // a zero-length option never fills a field, so it just closes here
        len_d      = b;
        off_d      = 8'd0;
        stage_d[0] = 32'd0;
        stage_d[1] = 32'd0;
        phase_d    = (b == 8'd0) ? PH_CODE : PH_VALUE;
      end
      PH_VALUE: begin
        if (off_q < 8'd8) begin
          stage_d[off_q[2]][{lane, 3'b000} +: 8] = b;
        end
        off_d = off_q + 8'd1;
        if (off_d >= len_q) begin
          commit  = 1'b1;
          phase_d = PH_CODE;
        end
      end
      PH_STOP, PH_BAD: begin
      end
      default: begin
      end
    endcase

    if (commit) begin
      if (code_q == OPT_MSG_TYPE) begin
        if (len_q != 8'd0) begin
          type_d = stage_d[0][31:24];
        end
      end else if (len_q >= 8'd4) begin
        unique case (code_q)
          OPT_SUBNET:    field_d[F_MASK]   = stage_d[0];
          OPT_ROUTER:    field_d[F_ROUTER] = stage_d[0];
          OPT_DNS: begin
            field_d[F_DNS1] = stage_d[0];
            if (len_q >= 8'd8) begin
              field_d[F_DNS2] = stage_d[1];
            end
          end
          OPT_BROADCAST: field_d[F_BCAST]  = stage_d[0];
          OPT_LEASE:     field_d[F_LEASE]  = stage_d[0];
          OPT_SERVER:    field_d[F_SERVER] = stage_d[0];
          OPT_RENEWAL:   field_d[F_RENEW]  = stage_d[0];
          OPT_REBIND:    field_d[F_REBIND] = stage_d[0];
          default: begin
          end
        endcase
      end
    end
  end

  // summary built from the state as it stands after this byte
  always_comb begin
    res_data_o = '0;
    if (phase_d == PH_COOKIE || phase_d == PH_BAD) begin
      res_data_o.status = 1'b1;
    end else begin
      res_data_o.message_type    = type_d;
      res_data_o.netmask         = field_d[F_MASK];
      res_data_o.router          = field_d[F_ROUTER];
      res_data_o.dns_primary     = field_d[F_DNS1];
      res_data_o.dns_secondary   = field_d[F_DNS2];
      res_data_o.broadcast_addr  = field_d[F_BCAST];
      res_data_o.lease_seconds   = field_d[F_LEASE];
      res_data_o.server_id       = field_d[F_SERVER];
      res_data_o.renewal_seconds = field_d[F_RENEW];
      res_data_o.rebind_seconds  = field_d[F_REBIND];
    end
  end

  assign res_valid_o = take_i && in_data_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COOKIE;
      cnt_q   <= 2'd0;
      code_q  <= 8'd0;
      len_q   <= 8'd0;
      off_q   <= 8'd0;
      stage_q <= '{default: 32'd0};
      field_q <= '{default: 32'd0};
      type_q  <= 8'd0;
    end else if (take_i) begin
      if (in_data_i.last) begin
        phase_q <= PH_COOKIE;
        cnt_q   <= 2'd0;
        code_q  <= 8'd0;
        len_q   <= 8'd0;
        off_q   <= 8'd0;
        stage_q <= '{default: 32'd0};
        field_q <= '{default: 32'd0};
        type_q  <= 8'd0;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        code_q  <= code_d;
        len_q   <= len_d;
        off_q   <= off_d;
        stage_q <= stage_d;
        field_q <= field_d;
        type_q  <= type_d;
      end
    end
  end

endmodule

@@ rtl/core/dop_skid.sv @@
module dop_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dop_pkg::dop_out_t push_data_i,
  output logic              push_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dop_pkg::dop_out_t out_data_o
);
  import dop_pkg::*;

  dop_out_t out_q;
  dop_out_t skid_q;
  logic     out_valid_q;
  logic     skid_valid_q;
  logic     pop;

  assign pop          = out_valid_q && out_ready_i;
  assign push_ready_o = !skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !pop) begin
      if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end else begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !pop) begin
      if (push_i) begin
        skid_q <= push_data_i;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (push_i) begin
      out_q <= push_data_i;
    end
  end

endmodule

@@ rtl/core/dhcp_option_parser.sv @@
// a last word's summary is registered in the result register or the skid entry
// throughput: one options byte per cycle; the per-byte parse is one state update
// output side has a result register plus one skid entry, so input stalls only
// when both hold an untaken summary
// reset: asynchronous active low, parser returns to cookie check, fields cleared
module dhcp_option_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dop_pkg::dop_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dop_pkg::dop_out_t out_data_o
);
  import dop_pkg::*;

  // word accepted this cycle
  logic     take;
  // summary produced by the word marked last
  logic     res_valid;
  dop_out_t res_data;

  assign take = in_valid_i && in_ready_o;

  // cookie check, option walk and field commit, one byte per accepted word
  dop_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  // result register with skid entry, decouples input from output backpressure
  dop_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_valid),
    .push_data_i  (res_data),
    .push_ready_o (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ dv/dop_tb_pkg.sv @@
package dop_tb_pkg;

  // magic cookie that opens every options area
  localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

  // option codes the parser knows about
  localparam logic [7:0] OPT_PAD         = 8'd0;
  localparam logic [7:0] OPT_SUBNET_MASK = 8'd1;
  localparam logic [7:0] OPT_ROUTER      = 8'd3;
  localparam logic [7:0] OPT_DNS         = 8'd6;
  localparam logic [7:0] OPT_BROADCAST   = 8'd28;
  localparam logic [7:0] OPT_LEASE       = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE    = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID   = 8'd54;
  localparam logic [7:0] OPT_RENEWAL     = 8'd58;
  localparam logic [7:0] OPT_REBIND      = 8'd59;
  localparam logic [7:0] OPT_END         = 8'd255;

endpackage

@@ dv/dhcp_option_parser_chk.sv @@
module dhcp_option_parser_chk (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  dop_pkg::dop_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  dop_pkg::dop_out_t out_data_i,
  output int unsigned       error_count_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dop_pkg::*;
  import dop_tb_pkg::*;

  typedef enum logic [2:0] {
    PH_COOKIE,
    PH_CODE,
    PH_LENGTH,
    PH_VALUE,
    PH_STOPPED,
    PH_BAD_COOKIE
  } parse_phase_e;

  parse_phase_e phase_q;
  logic [2:0]   cookie_seen;
  logic [7:0]   cur_code;
  logic [7:0]   cur_len;
  logic [7:0]   cur_off;
  logic [63:0]  staged_value;   // first eight value bytes, big-endian
  dop_out_t     parsed;         // committed options of this packet
  dop_out_t     summary_q[$];   // summaries still owed by the block

  task automatic report_error(input string msg);
    $display("[%0t] dhcp parser mismatch: %s", $time, msg);
    error_count_o++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic clear_packet();
    phase_q      = PH_COOKIE;
    cookie_seen  = '0;
    cur_code     = '0;
    cur_len      = '0;
    cur_off      = '0;
    staged_value = '0;
    parsed       = '0;
  endtask

  task automatic commit_option();
    if (cur_code == OPT_MSG_TYPE) begin
      if (cur_len >= 8'd1) parsed.message_type = staged_value[63:56];
    end else if (cur_len >= 8'd4) begin
      case (cur_code)
        OPT_SUBNET_MASK: parsed.netmask         = staged_value[63:32];
        OPT_ROUTER:      parsed.router          = staged_value[63:32];
        OPT_DNS: begin
          parsed.dns_primary = staged_value[63:32];
          if (cur_len >= 8'd8) parsed.dns_secondary = staged_value[31:0];
        end
        OPT_BROADCAST:   parsed.broadcast_addr  = staged_value[63:32];
        OPT_LEASE:       parsed.lease_seconds   = staged_value[63:32];
        OPT_SERVER_ID:   parsed.server_id       = staged_value[63:32];
        OPT_RENEWAL:     parsed.renewal_seconds = staged_value[63:32];
        OPT_REBIND:      parsed.rebind_seconds  = staged_value[63:32];
        default: ;
      endcase
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int idx;
    case (phase_q)
      PH_COOKIE: begin
        idx = cookie_seen;
        if (b != MAGIC_COOKIE[8*(3-idx) +: 8]) begin
          phase_q = PH_BAD_COOKIE;
        end else begin
          cookie_seen++;
          if (cookie_seen == 3'd4) phase_q = PH_CODE;
        end
      end
      PH_CODE: begin
        if (b == OPT_END) begin
          phase_q = PH_STOPPED;
        end else if (b != OPT_PAD) begin
          cur_code = b;
          phase_q  = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        cur_len      = b;
        cur_off      = '0;
        staged_value = '0;
        if (b == 8'd0) begin
          commit_option();
          phase_q = PH_CODE;
        end else begin
          phase_q = PH_VALUE;
        end
      end
      PH_VALUE: begin
        idx = cur_off;
        if (idx < 8) staged_value[63 - 8*idx -: 8] = b;
        cur_off++;
        if (cur_off >= cur_len) begin
          commit_option();
          phase_q = PH_CODE;
        end
      end
      default: ;
    endcase
  endtask

  // summary owed on a word marked last
  task automatic close_packet();
    dop_out_t want;
    if (phase_q == PH_COOKIE || phase_q == PH_BAD_COOKIE) begin
      want        = '0;
      want.status = 1'b1;
    end else begin
      want        = parsed;
      want.status = 1'b0;
    end
    summary_q.push_back(want);
    clear_packet();
  endtask

  task automatic check_summary(input dop_out_t got);
    dop_out_t want;
    if (summary_q.size() == 0) begin
      report_error("summary with none pending");
      return;
    end
    want = summary_q.pop_front();
    compare_field("status", 32'(got.status), 32'(want.status));
    compare_field("message_type", 32'(got.message_type), 32'(want.message_type));
    compare_field("netmask", got.netmask, want.netmask);
    compare_field("router", got.router, want.router);
    compare_field("dns_primary", got.dns_primary, want.dns_primary);
    compare_field("dns_secondary", got.dns_secondary, want.dns_secondary);
    compare_field("broadcast_addr", got.broadcast_addr, want.broadcast_addr);
    compare_field("lease_seconds", got.lease_seconds, want.lease_seconds);
    compare_field("server_id", got.server_id, want.server_id);
    compare_field("renewal_seconds", got.renewal_seconds, want.renewal_seconds);
    compare_field("rebind_seconds", got.rebind_seconds, want.rebind_seconds);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_packet();
      summary_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_summary(out_data_i);
      if (in_valid_i && in_ready_i) begin
        absorb_byte(in_data_i.data_byte);
        if (in_data_i.last) close_packet();
      end
    end
    pending_o = summary_q.size();
  end

endmodule

@@ dv/dhcp_option_parser_tb.sv @@
module dhcp_option_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dop_pkg::*;
  import dop_tb_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1700;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  dop_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  dop_out_t    out_data;
  int unsigned errors;
  int unsigned pending;

  // shared by both sides: when set, neither the sender nor the receiver idles
  bit          steady    = 1'b0;

  logic [7:0]  pkt[$];        // options area being built
  int unsigned words_sent = 0;

  // option codes the random part draws from
  logic [7:0] known_codes[9] = '{OPT_SUBNET_MASK, OPT_ROUTER, OPT_DNS, OPT_BROADCAST,
                                 OPT_LEASE, OPT_MSG_TYPE, OPT_SERVER_ID, OPT_RENEWAL,
                                 OPT_REBIND};

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  dhcp_option_parser u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  dhcp_option_parser_chk u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  // offer one word, holding it until the parser takes it; called and
  // returning at a falling edge so valid is only ever assigned once per step
  task automatic send_word(input logic [7:0] b, input logic is_last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last: is_last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  // push the built area out, last mark on its final byte
  task automatic send_packet();
    foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1);
    pkt.delete();
  endtask

  // code, length, then only 'sent' random value bytes (fewer than len truncates)
  task automatic add_option(input logic [7:0] code, input int len, input int sent);
    pkt.push_back(code);
    pkt.push_back(8'(len));
    repeat (sent) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  // good cookie, or one with a single wrong byte; a cut-off prefix is
  // returned as 1 when the packet should end right there
  function automatic bit add_cookie(input bit corrupt);
    int bad_pos;
    int keep;
    for (int i = 0; i < 4; i++) pkt.push_back(MAGIC_COOKIE[8*(3-i) +: 8]);
    if (!corrupt) return 1'b0;
    if ($urandom_range(0, 2) == 0) begin
      // packet ends inside an otherwise correct cookie
      keep = $urandom_range(1, 3);
      while (pkt.size() > keep) void'(pkt.pop_back());
      return 1'b1;
    end
    bad_pos = $urandom_range(0, 3);
    pkt[bad_pos] = pkt[bad_pos] ^ 8'($urandom_range(1, 255));
    return 1'b0;
  endfunction

  function automatic logic [7:0] pick_code();
    return known_codes[$urandom_range(0, 8)];
  endfunction

  // mostly the length the option wants, sometimes too short, long or huge
  function automatic int pick_length(input logic [7:0] code);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if (code == OPT_MSG_TYPE) return 1;
      if (code == OPT_DNS) return $urandom_range(0, 1) ? 8 : 4;
      return 4;
    end
    if (r < 82) return (code == OPT_MSG_TYPE) ? 0 : $urandom_range(0, 3);
    if (r < 99) return $urandom_range(5, 12);
    return $urandom_range(200, 255);
  endfunction

  task automatic add_random_option();
    int r;
    int len;
    logic [7:0] code;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      pkt.push_back(OPT_PAD);
    end else begin
      // unknown codes get skipped by their length
      code = (r == 1) ? 8'($urandom_range(1, 254)) : pick_code();
      len  = pick_length(code);
      add_option(code, len, len);
    end
  endtask

  task automatic build_random_packet();
    int kind;
    int n_opts;
    int ending;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // raw noise, almost always a bad cookie
      repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (add_cookie(kind < 18)) return;
    n_opts = $urandom_range(0, 6);
    repeat (n_opts) add_random_option();
    ending = $urandom_range(0, 99);
    if (ending < 45) begin
      // end option, then trailing bytes that must be ignored
      pkt.push_back(OPT_END);
      repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom_range(0, 255)));
    end else if (ending < 55) begin
      pkt.push_back(OPT_PAD);
    end else if (ending < 65) begin
      // stops on a bare code byte
      pkt.push_back(8'($urandom_range(1, 254)));
    end else if (ending < 75) begin
      // stops on the length byte
      pkt.push_back(pick_code());
      pkt.push_back(8'($urandom_range(0, 12)));
    end else if (ending < 87) begin
      // value bytes cut short
      len = $urandom_range(2, 12);
      add_option(pick_code(), len, $urandom_range(1, len - 1));
    end else begin
      // last mark on the final value byte of a complete option
      len = pick_length(OPT_DNS);
      add_option(pick_code(), len + 1, len + 1);
    end
  endtask

  task automatic run_directed();
    // lone zero byte: cookie wrong on its first byte
    pkt.push_back(8'h00);
    send_packet();
    // packet ends inside a correct cookie
    for (int i = 0; i < 3; i++) pkt.push_back(MAGIC_COOKIE[8*(3-i) +: 8]);
    send_packet();
    // second cookie byte wrong, all-ones data
    pkt.push_back(MAGIC_COOKIE[31:24]);
    pkt.push_back(8'hFF);
    send_packet();
    // message type at max, pad, short lease, zero-length mask, end, trailing byte
    void'(add_cookie(1'b0));
    pkt.push_back(OPT_MSG_TYPE);
    pkt.push_back(8'd1);
    pkt.push_back(8'hFF);
    pkt.push_back(OPT_PAD);
    add_option(OPT_LEASE, 2, 2);
    add_option(OPT_SUBNET_MASK, 0, 0);
    pkt.push_back(OPT_END);
    pkt.push_back(8'h12);
    send_packet();
    // dns with nine value bytes (ninth skipped), then ends on a code byte
    void'(add_cookie(1'b0));
    pkt.push_back(OPT_DNS);
    pkt.push_back(8'd9);
    for (int i = 0; i < 9; i++) pkt.push_back(8'(8'hF8 + i));
    pkt.push_back(8'd7);
    send_packet();
  endtask

  // receiver: random stall before each summary, none while steady
  initial begin
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    while (words_sent < RANDOM_WORDS) begin
      // about one packet in five runs with both sides at full rate
      steady = ($urandom_range(0, 4) == 0);
      build_random_packet();
      send_packet();
    end
    steady = 1'b0;
    in_valid <= 1'b0;
    wait (pending == 0);
    // all owed summaries have been checked once pending is zero
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
